>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the inverted page table block
// Shared property wrappers, clocked on aclk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define IPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a condition is followed by a result on the next edge
`define IPT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/ipt_pkg.sv
// ---------------------------------------------------------------------------
// ipt_pkg
// Types, constants and helper functions of the inverted page table block.
// ---------------------------------------------------------------------------
package ipt_pkg;

    // Table geometry
    localparam int NUM_FRAMES  = 64;
    localparam int PAGE_BITS   = 20;
    localparam int FRAME_IDX_W = $clog2(NUM_FRAMES);
    localparam int GRP_SIZE    = 8;
    localparam int GRP_IDX_W   = $clog2(GRP_SIZE);
    localparam int GRP_CNT_W   = $clog2(GRP_SIZE + 1);
    localparam int NUM_GRPS    = NUM_FRAMES / GRP_SIZE;
    localparam int NUM_GRPS_W  = FRAME_IDX_W - GRP_IDX_W;

    // Field widths
    localparam int PID_W  = 2;
    localparam int PF_W   = 7;
    localparam int WB_W   = 7;
    localparam int CNT_W  = 32;
    localparam int LIM_W  = 7;

    localparam logic [PF_W-1:0]  PF_MAX    = '1;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    // Process codes; owner code zero means an unowned frame
    localparam logic [PID_W-1:0] OWNER_NONE = 2'd0;
    localparam logic [PID_W-1:0] PID_A      = 2'd1;
    localparam logic [PID_W-1:0] PID_B      = 2'd2;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_FAULT_LIMIT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAMES_IN_USE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRACE_LIMIT   = 2'd2;

    localparam logic [LIM_W-1:0] FAULT_LIMIT_RST   = 7'd32;
    localparam logic [LIM_W-1:0] FRAMES_IN_USE_RST = 7'd64;
    localparam logic [CNT_W-1:0] TRACE_LIMIT_RST   = '1;

    // Stream packing
    localparam int S_PID_LSB   = 0;
    localparam int S_PAGE_LSB  = S_PID_LSB + PID_W;
    localparam int S_FIELDS_W  = S_PAGE_LSB + PAGE_BITS;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = 4 + WB_W + 3 * CNT_W + 1;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_FCOUNT,
        ST_FAPPLY,
        ST_EMIT
    } ipt_state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load_item;
        logic look;
        logic decide;
        logic fcount;
        logic fapply;
        logic emit;
    } ipt_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic final_due;
        logic out_free;
    } ipt_stat_t;

    // Count set bits in one group of frames
    function automatic logic [GRP_CNT_W-1:0] grp_popcount(input logic [GRP_SIZE-1:0] v);
        logic [GRP_CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < GRP_SIZE; i++) begin
            c = c + GRP_CNT_W'(v[i]);
        end
        return c;
    endfunction

    // Lowest set bit in one group of frames
    function automatic logic [GRP_IDX_W-1:0] grp_first(input logic [GRP_SIZE-1:0] v);
        logic [GRP_IDX_W-1:0] idx;
        idx = '0;
        for (int i = GRP_SIZE - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = GRP_IDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [WB_W-1:0]  b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W + 1)'(b);
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

>>> src/inverted_page_table_fwf.sv
// ---------------------------------------------------------------------------
// inverted_page_table_fwf
// Inverted frame table shared by two processes with flush-when-full
// replacement, one result beat per reference beat.
// ---------------------------------------------------------------------------
// Each reference passes through accept, lookup across all frames, table
// update and result load; at the trace limit the final flush adds a second
// pass through the registered write-back count tree and a clear. One
// reference is in flight at a time; the next beat is taken once the previous
// result has been loaded, and a result waiting on m_tready holds the block in
// its result step. All 64 frames are matched in parallel in the lookup cycle;
// dirty counts and free-frame search go through groups of eight frames that
// are registered before the update. Configuration must be written only while
// idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module inverted_page_table_fwf (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port
    input  logic                           cfg_we,
    input  logic [ipt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ipt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Reference stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: process_id[1:0], page_number[21:2], zero pad[23:22]
    input  logic [ipt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: is_write
    input  logic                           s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: hit[0], fault[1], process_flushed[2], placed[3],
    // writebacks_now[10:4], total_faults[42:11], total_writebacks[74:43],
    // reference_count[106:75], done_res[107], zero pad[111:108]
    output logic [ipt_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ipt_pkg::*;

    ipt_cmd_t  cmd;
    ipt_stat_t stat;

    ipt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ipt_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> src/ipt_ctrl.sv
// ---------------------------------------------------------------------------
// ipt_ctrl
// Sequencer: steps one reference through lookup, update, optional final
// flush and result hand-off.
// ---------------------------------------------------------------------------
module ipt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ipt_pkg::ipt_stat_t stat,
    output ipt_pkg::ipt_cmd_t  cmd
);
    import ipt_pkg::*;

    ipt_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = stat.final_due ? ST_FCOUNT : ST_EMIT;
            ST_FCOUNT: state_next = ST_FAPPLY;
            ST_FAPPLY: state_next = ST_EMIT;
            ST_EMIT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Command decode
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_LOOK:   cmd.look   = 1'b1;
            ST_DECIDE: cmd.decide = 1'b1;
            ST_FCOUNT: cmd.fcount = 1'b1;
            ST_FAPPLY: cmd.fapply = 1'b1;
            ST_EMIT:   cmd.emit   = stat.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

>>> src/ipt_datapath.sv
// ---------------------------------------------------------------------------
// ipt_datapath
// Frame table, per-process fault counts, totals, configuration registers
// and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ipt_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ipt_pkg::ipt_cmd_t                   cmd,
    output ipt_pkg::ipt_stat_t                  stat,
    input  logic                                cfg_we,
    input  logic [ipt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [ipt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [ipt_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ipt_pkg::M_TDATA_W-1:0]       m_tdata
);
    import ipt_pkg::*;

    // Configuration
    logic [LIM_W-1:0] fault_limit_reg;
    logic [LIM_W-1:0] frames_in_use_reg;
    logic [CNT_W-1:0] trace_limit_reg;

    // Current reference
    logic [PID_W-1:0]     pid_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 wr_reg;

    // Frame table
    logic [PID_W-1:0]     owner_reg [NUM_FRAMES];
    logic [PID_W-1:0]     owner_next [NUM_FRAMES];
    logic [PAGE_BITS-1:0] page_mem [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic [NUM_FRAMES-1:0] dirty_reg, dirty_next;

    // Lookup stage
    logic [NUM_FRAMES-1:0] in_range;
    logic [NUM_FRAMES-1:0] match_next, match_reg;
    logic [NUM_FRAMES-1:0] cnt_mask, free_a, free_b;
    logic [GRP_CNT_W-1:0]  grp_cnt_next [NUM_GRPS];
    logic [GRP_CNT_W-1:0]  grp_cnt_reg  [NUM_GRPS];
    logic [NUM_GRPS-1:0]   any_a_reg, any_b_reg;
    logic [GRP_IDX_W-1:0]  idx_a_reg [NUM_GRPS];
    logic [GRP_IDX_W-1:0]  idx_b_reg [NUM_GRPS];

    // Counters
    logic [PF_W-1:0]  pf_reg [2];
    logic [CNT_W-1:0] fault_total_reg;
    logic [CNT_W-1:0] wb_total_reg;
    logic [CNT_W-1:0] seen_reg;
    logic             finished_reg;

    // Per-item results
    logic            hit_res_reg, fault_res_reg, pflush_res_reg, placed_res_reg;
    logic [WB_W-1:0] wbnow_res_reg;

    // Output register
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // Update stage signals
    logic                   pid_ok, any_match, hit, fault, pflush, placed, found;
    logic                   pidx;
    logic [PF_W-1:0]        pf_inc;
    logic [NUM_GRPS_W-1:0]  grp_sel;
    logic [GRP_IDX_W-1:0]   grp_idx;
    logic [FRAME_IDX_W-1:0] place_idx;
    logic [WB_W-1:0]        grp_sum, proc_wb;
    logic [CNT_W-1:0]       seen_inc;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_limit_reg   <= FAULT_LIMIT_RST;
            frames_in_use_reg <= FRAMES_IN_USE_RST;
            trace_limit_reg   <= TRACE_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FAULT_LIMIT:   fault_limit_reg   <= cfg_wdata[LIM_W-1:0];
                REG_FRAMES_IN_USE: frames_in_use_reg <= cfg_wdata[LIM_W-1:0];
                REG_TRACE_LIMIT:   trace_limit_reg   <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Latch the accepted beat
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            pid_reg  <= s_tdata[S_PID_LSB +: PID_W];
            page_reg <= s_tdata[S_PAGE_LSB +: PAGE_BITS];
            wr_reg   <= s_tuser;
        end
    end

    // Frames taking part in search and allocation
    always_comb begin
        for (int j = 0; j < NUM_FRAMES; j++) begin
            in_range[j] = (32'(j) < 32'(frames_in_use_reg));
        end
    end

    // Per-frame match, write-back and free masks
    always_comb begin
        for (int j = 0; j < NUM_FRAMES; j++) begin
            match_next[j] = valid_reg[j] && in_range[j] && (owner_reg[j] == pid_reg)
                            && (page_mem[j] == page_reg);
            cnt_mask[j]   = valid_reg[j] && dirty_reg[j] && in_range[j]
                            && (cmd.fcount || (owner_reg[j] == pid_reg));
            free_a[j]     = in_range[j] && !valid_reg[j]
                            && ((owner_reg[j] == pid_reg) || (owner_reg[j] == OWNER_NONE));
            free_b[j]     = in_range[j] && ((owner_reg[j] == pid_reg)
                            || ((owner_reg[j] == OWNER_NONE) && !valid_reg[j]));
        end
        for (int g = 0; g < NUM_GRPS; g++) begin
            grp_cnt_next[g] = grp_popcount(cnt_mask[g*GRP_SIZE +: GRP_SIZE]);
        end
    end

    // Register the match vector and group results of the lookup and final count
    always_ff @(posedge aclk) begin
        if (cmd.look) begin
            match_reg <= match_next;
            for (int g = 0; g < NUM_GRPS; g++) begin
                any_a_reg[g] <= |free_a[g*GRP_SIZE +: GRP_SIZE];
                any_b_reg[g] <= |free_b[g*GRP_SIZE +: GRP_SIZE];
                idx_a_reg[g] <= grp_first(free_a[g*GRP_SIZE +: GRP_SIZE]);
                idx_b_reg[g] <= grp_first(free_b[g*GRP_SIZE +: GRP_SIZE]);
            end
        end
        if (cmd.look || cmd.fcount) begin
            for (int g = 0; g < NUM_GRPS; g++) begin
                grp_cnt_reg[g] <= grp_cnt_next[g];
            end
        end
    end

    // Hit, fault, flush and placement decision
    always_comb begin
        pid_ok    = (pid_reg == PID_A) || (pid_reg == PID_B);
        any_match = |match_reg;
        hit       = !finished_reg && pid_ok && any_match;
        fault     = !finished_reg && pid_ok && !any_match;
        pidx      = pid_reg[1];
        pf_inc    = (pf_reg[pidx] < PF_MAX) ? pf_reg[pidx] + 1'b1 : pf_reg[pidx];
        pflush    = fault && (pf_inc > fault_limit_reg);

        grp_sel = '0;
        found   = 1'b0;
        for (int g = NUM_GRPS - 1; g >= 0; g--) begin
            if (pflush ? any_b_reg[g] : any_a_reg[g]) begin
                grp_sel = NUM_GRPS_W'(g);
                found   = 1'b1;
            end
        end
        grp_idx   = pflush ? idx_b_reg[grp_sel] : idx_a_reg[grp_sel];
        place_idx = {grp_sel, grp_idx};
        placed    = fault && found;

        grp_sum = '0;
        for (int g = 0; g < NUM_GRPS; g++) begin
            grp_sum = grp_sum + WB_W'(grp_cnt_reg[g]);
        end
        proc_wb  = pflush ? grp_sum : '0;
        seen_inc = sat_inc(seen_reg);
    end

    assign stat.final_due = !finished_reg && (seen_inc == trace_limit_reg);
    assign stat.out_free  = !m_valid_reg || m_tready;

    // Frame table next values: dirty on write hit, process flush, load, final flush
    always_comb begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        owner_next = owner_reg;
        if (cmd.decide) begin
            for (int j = 0; j < NUM_FRAMES; j++) begin
                if (hit && wr_reg && match_reg[j]) begin
                    dirty_next[j] = 1'b1;
                end
                if (pflush && in_range[j] && (owner_reg[j] == pid_reg)) begin
                    valid_next[j] = 1'b0;
                    dirty_next[j] = 1'b0;
                end
                if (placed && (place_idx == FRAME_IDX_W'(j))) begin
                    owner_next[j] = pid_reg;
                    valid_next[j] = 1'b1;
                    dirty_next[j] = wr_reg;
                end
            end
        end else if (cmd.fapply) begin
            for (int j = 0; j < NUM_FRAMES; j++) begin
                if (in_range[j]) begin
                    valid_next[j] = 1'b0;
                    dirty_next[j] = 1'b0;
                end
            end
        end
    end

    // Frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int j = 0; j < NUM_FRAMES; j++) begin
                owner_reg[j] <= OWNER_NONE;
            end
        end else begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            owner_reg <= owner_next;
        end
    end

    // Page store, written on load only
    always_ff @(posedge aclk) begin
        if (cmd.decide && placed) begin
            page_mem[place_idx] <= page_reg;
        end
    end

    // Counters and per-item results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pf_reg[0]       <= '0;
            pf_reg[1]       <= '0;
            fault_total_reg <= '0;
            wb_total_reg    <= '0;
            seen_reg        <= '0;
            finished_reg    <= 1'b0;
            hit_res_reg     <= 1'b0;
            fault_res_reg   <= 1'b0;
            pflush_res_reg  <= 1'b0;
            placed_res_reg  <= 1'b0;
            wbnow_res_reg   <= '0;
        end else if (cmd.decide) begin
            if (fault) begin
                fault_total_reg <= sat_inc(fault_total_reg);
                pf_reg[pidx]    <= pflush ? PF_W'(1) : pf_inc;
            end
            wb_total_reg <= sat_add(wb_total_reg, proc_wb);
            if (!finished_reg) begin
                seen_reg <= seen_inc;
            end
            hit_res_reg    <= hit;
            fault_res_reg  <= fault;
            pflush_res_reg <= pflush;
            placed_res_reg <= placed;
            wbnow_res_reg  <= proc_wb;
        end else if (cmd.fapply) begin
            wb_total_reg  <= sat_add(wb_total_reg, grp_sum);
            wbnow_res_reg <= wbnow_res_reg + grp_sum;
            finished_reg  <= 1'b1;
        end
    end

    // Result register: hold until taken, reload on emit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {(M_TDATA_W - M_FIELDS_W)'(0), finished_reg, seen_reg,
                           wb_total_reg, fault_total_reg, wbnow_res_reg,
                           placed_res_reg, pflush_res_reg, fault_res_reg, hit_res_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    `IPT_ASSERT(a_hit_not_fault, !(hit_res_reg && fault_res_reg), "hit and fault together")
    `IPT_ASSERT(a_placed_is_fault, placed_res_reg |-> fault_res_reg, "load without fault")
    `IPT_ASSERT(a_wb_bound, wbnow_res_reg <= WB_W'(NUM_FRAMES), "write-backs exceed frames")
    `IPT_ASSERT(a_done_frozen, (finished_reg && $past(finished_reg)) |-> ($stable(fault_total_reg) && $stable(seen_reg)), "state moved after finish")
    `IPT_ASSERT_NEXT(a_final_sets_done, cmd.fapply, finished_reg && (valid_reg & in_range) == '0, "final flush incomplete")

endmodule

>>> sim/ipt_outcome_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipt_outcome_check
// Watches the configuration port and both stream channels of the inverted
// page table, keeps its own copy of the frame table and counters, predicts
// the outcome of every accepted reference beat and compares each result beat
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module ipt_outcome_check (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ipt_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ipt_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // s_tdata: process_id, page_number, zero pad
    input  logic [ipt_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: is_write
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: hit, fault, process_flushed, placed, writebacks_now,
    // total_faults, total_writebacks, reference_count, done_res, zero pad
    input  logic [ipt_pkg::M_TDATA_W-1:0]  m_tdata,
    output int                             fail_count,
    output int                             pending
);
    import ipt_pkg::*;

    // Result field positions, lowest bit up
    localparam int HIT_BIT    = 0;
    localparam int FAULT_BIT  = 1;
    localparam int PFLUSH_BIT = 2;
    localparam int PLACED_BIT = 3;
    localparam int WB_LSB     = 4;
    localparam int TF_LSB     = WB_LSB + WB_W;
    localparam int TW_LSB     = TF_LSB + CNT_W;
    localparam int RC_LSB     = TW_LSB + CNT_W;
    localparam int DONE_BIT   = RC_LSB + CNT_W;

    typedef struct packed {
        logic             hit;
        logic             fault;
        logic             pflush;
        logic             placed;
        logic [WB_W-1:0]  wb_now;
        logic [CNT_W-1:0] faults;
        logic [CNT_W-1:0] writebacks;
        logic [CNT_W-1:0] refs;
        logic             done;
    } ref_outcome_t;

    // Shadow frame table
    logic [PID_W-1:0]     frame_owner [NUM_FRAMES];
    logic [PAGE_BITS-1:0] frame_page  [NUM_FRAMES];
    logic                 frame_dirty [NUM_FRAMES];
    logic                 frame_valid [NUM_FRAMES];

    // Shadow counters and configuration
    logic [PF_W-1:0]  proc_faults [2];
    logic [CNT_W-1:0] fault_total;
    logic [CNT_W-1:0] writeback_total;
    logic [CNT_W-1:0] seen_count;
    logic             finished;
    logic [LIM_W-1:0] fault_limit;
    logic [LIM_W-1:0] frames_in_use;
    logic [CNT_W-1:0] trace_limit;

    ref_outcome_t outcome_q[$];

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Drop valid frames of one owner, or of every owner when owner is none;
    // return how many of them were dirty
    function automatic logic [WB_W-1:0] flush_frames(input int n, input logic [PID_W-1:0] owner);
        logic [WB_W-1:0] dirty_cnt;
        dirty_cnt = '0;
        for (int j = 0; j < n; j++) begin
            if (frame_valid[j] && (owner == OWNER_NONE || frame_owner[j] == owner)) begin
                if (frame_dirty[j]) begin
                    dirty_cnt++;
                    writeback_total = sat_bump(writeback_total);
                end
                frame_valid[j] = 1'b0;
                frame_dirty[j] = 1'b0;
            end
        end
        return dirty_cnt;
    endfunction

    // Look up one reference, update the shadow table and return its outcome
    task automatic resolve_reference(input logic [PID_W-1:0] pid,
                                     input logic [PAGE_BITS-1:0] pg,
                                     input logic wr,
                                     output ref_outcome_t o);
        int n;
        logic p;
        logic found;
        logic [WB_W-1:0] wb;
        n  = (frames_in_use < NUM_FRAMES) ? int'(frames_in_use) : NUM_FRAMES;
        o  = '0;
        wb = '0;
        if (!finished) begin
            if (pid == PID_A || pid == PID_B) begin
                p = (pid == PID_A) ? 1'b0 : 1'b1;
                for (int j = 0; j < n; j++) begin
                    if (frame_valid[j] && frame_owner[j] == pid && frame_page[j] == pg) begin
                        if (wr)
                            frame_dirty[j] = 1'b1;
                        o.hit = 1'b1;
                    end
                end
                if (!o.hit) begin
                    o.fault = 1'b1;
                    fault_total = sat_bump(fault_total);
                    if (proc_faults[p] != PF_MAX)
                        proc_faults[p]++;
                    // Over the limit: flush this process's frames first
                    if (proc_faults[p] > fault_limit) begin
                        o.pflush = 1'b1;
                        wb += flush_frames(n, pid);
                        proc_faults[p] = PF_W'(1);
                    end
                    // Load into the first free frame this process may take
                    found = 1'b0;
                    for (int j = 0; j < n; j++) begin
                        if (!found && !frame_valid[j] &&
                            (frame_owner[j] == pid || frame_owner[j] == OWNER_NONE)) begin
                            frame_owner[j] = pid;
                            frame_page[j]  = pg;
                            frame_valid[j] = 1'b1;
                            frame_dirty[j] = wr;
                            found = 1'b1;
                        end
                    end
                    o.placed = found;
                end
            end
            seen_count = sat_bump(seen_count);
            if (seen_count == trace_limit) begin
                wb += flush_frames(n, OWNER_NONE);
                finished = 1'b1;
            end
        end
        o.wb_now     = wb;
        o.faults     = fault_total;
        o.writebacks = writeback_total;
        o.refs       = seen_count;
        o.done       = finished;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                               input logic [CNT_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, predicted 0x%0h", name, got, want));
    endtask

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    always @(posedge aclk) begin
        ref_outcome_t want;
        ref_outcome_t fresh;
        if (!aresetn) begin
            for (int j = 0; j < NUM_FRAMES; j++) begin
                frame_owner[j] = OWNER_NONE;
                frame_page[j]  = '0;
                frame_dirty[j] = 1'b0;
                frame_valid[j] = 1'b0;
            end
            proc_faults[0]  = '0;
            proc_faults[1]  = '0;
            fault_total     = '0;
            writeback_total = '0;
            seen_count      = '0;
            finished        = 1'b0;
            fault_limit     = FAULT_LIMIT_RST;
            frames_in_use   = FRAMES_IN_USE_RST;
            trace_limit     = TRACE_LIMIT_RST;
            outcome_q.delete();
        end else begin
            // Compare a result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result beat with no reference outstanding");
                end else begin
                    want = outcome_q.pop_front();
                    check_field("hit", CNT_W'(m_tdata[HIT_BIT]), CNT_W'(want.hit));
                    check_field("fault", CNT_W'(m_tdata[FAULT_BIT]), CNT_W'(want.fault));
                    check_field("process_flushed", CNT_W'(m_tdata[PFLUSH_BIT]),
                                CNT_W'(want.pflush));
                    check_field("placed", CNT_W'(m_tdata[PLACED_BIT]), CNT_W'(want.placed));
                    check_field("writebacks_now", CNT_W'(m_tdata[WB_LSB +: WB_W]),
                                CNT_W'(want.wb_now));
                    check_field("total_faults", m_tdata[TF_LSB +: CNT_W], want.faults);
                    check_field("total_writebacks", m_tdata[TW_LSB +: CNT_W], want.writebacks);
                    check_field("reference_count", m_tdata[RC_LSB +: CNT_W], want.refs);
                    check_field("done_res", CNT_W'(m_tdata[DONE_BIT]), CNT_W'(want.done));
                end
            end
            // Predict the outcome of an accepted reference beat
            if (s_tvalid && s_tready) begin
                resolve_reference(s_tdata[S_PID_LSB +: PID_W], s_tdata[S_PAGE_LSB +: PAGE_BITS],
                                  s_tuser, fresh);
                outcome_q.push_back(fresh);
            end
            // Track register writes
            if (cfg_we) begin
                case (cfg_addr)
                    REG_FAULT_LIMIT:   fault_limit   = cfg_wdata[LIM_W-1:0];
                    REG_FRAMES_IN_USE: frames_in_use = cfg_wdata[LIM_W-1:0];
                    REG_TRACE_LIMIT:   trace_limit   = cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
        pending = outcome_q.size();
    end

endmodule

>>> sim/inverted_page_table_fwf_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// inverted_page_table_fwf_tb
// Drives references into the inverted page table: a directed opening over
// field extremes, unknown processes, zero fault limit and zero frames, then
// random phases over several register settings ending with the trace limit
// and the final flush. Both channels stall in random bursts. Checking is
// done by ipt_outcome_check; this module gives the verdict.
// ---------------------------------------------------------------------------
module inverted_page_table_fwf_tb;
    import ipt_pkg::*;

    localparam logic [PID_W-1:0]     PID_UNKNOWN = 2'd3;
    localparam logic [PAGE_BITS-1:0] PAGE_TOP    = '1;
    localparam int                   STALL_LIMIT = 3000;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // s_tdata: process_id, page_number, zero pad
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    // s_tuser: is_write
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // m_tdata: hit, fault, process_flushed, placed, writebacks_now,
    // total_faults, total_writebacks, reference_count, done_res, zero pad
    logic [M_TDATA_W-1:0]  m_tdata;

    int fail_count;
    int pending;
    int refs_sent   = 0;
    int stall_count = 0;
    bit no_idle     = 1'b0;

    logic [PAGE_BITS-1:0] page_pool [32];
    int                   pool_size = 8;

    inverted_page_table_fwf u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ipt_outcome_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
                stall_count <= 0;
            end else if (stall_count >= STALL_LIMIT) begin
                $display("inverted_page_table_fwf_tb: done, errors");
                $finish;
            end else begin
                stall_count <= stall_count + 1;
            end
        end
    end

    // Result side: stall in random bursts until the last phase
    initial begin
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    // Send one reference beat, with an optional idle burst ahead of it
    task automatic send_ref(input logic [PID_W-1:0] pid, input logic [PAGE_BITS-1:0] pg,
                            input logic wr);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        // Process id in the low bits, page number above, pad on top
        s_tdata  <= S_TDATA_W'({pg, pid});
        s_tuser  <= wr;
        do @(posedge aclk); while (!s_tready);
        refs_sent++;
    endtask

    // Drain the block, then write all three registers
    task automatic program_table(input logic [CFG_DATA_W-1:0] fl,
                                 input logic [CFG_DATA_W-1:0] fiu,
                                 input logic [CFG_DATA_W-1:0] tl);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FAULT_LIMIT;
        cfg_wdata <= fl;
        @(posedge aclk);
        cfg_addr  <= REG_FRAMES_IN_USE;
        cfg_wdata <= fiu;
        @(posedge aclk);
        cfg_addr  <= REG_TRACE_LIMIT;
        cfg_wdata <= tl;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly pages from a small working set, some wide and extreme ones
    task automatic send_random();
        int r;
        int s;
        logic [PID_W-1:0]     pid;
        logic [PAGE_BITS-1:0] pg;
        r = $urandom_range(0, 99);
        if (r < 2)
            pid = OWNER_NONE;
        else if (r < 4)
            pid = PID_UNKNOWN;
        else
            pid = (r % 2 == 0) ? PID_A : PID_B;
        s = $urandom_range(0, 9);
        if (s < 7)
            pg = page_pool[5'($urandom_range(0, pool_size - 1))];
        else if (s < 9)
            pg = PAGE_BITS'($urandom);
        else
            pg = $urandom_range(0, 1) ? PAGE_TOP : '0;
        send_ref(pid, pg, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] fl, input logic [CFG_DATA_W-1:0] fiu,
                             input logic [CFG_DATA_W-1:0] tl, input int pool, input int count);
        program_table(fl, fiu, tl);
        pool_size = pool;
        foreach (page_pool[i])
            page_pool[i] = PAGE_BITS'($urandom);
        repeat (count) send_random();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: hits, misses, both processes, page extremes
        send_ref(PID_A, '0, 1'b0);
        send_ref(PID_A, '0, 1'b1);
        send_ref(PID_B, '0, 1'b0);
        send_ref(PID_A, PAGE_TOP, 1'b1);
        send_ref(PID_B, PAGE_TOP, 1'b0);
        send_ref(PID_A, PAGE_TOP, 1'b0);
        send_ref(OWNER_NONE, 20'd5, 1'b1);
        send_ref(PID_UNKNOWN, PAGE_TOP, 1'b1);
        send_ref(PID_B, '0, 1'b1);
        send_ref(PID_A, 20'h55555, 1'b1);
        send_ref(PID_B, 20'hAAAAA, 1'b0);

        // Zero fault limit on two frames: every fault flushes
        program_table(0, 2, CNT_MAX);
        send_ref(PID_A, 20'd1, 1'b1);
        send_ref(PID_A, 20'd2, 1'b1);
        send_ref(PID_B, 20'd3, 1'b0);
        send_ref(PID_B, 20'd3, 1'b1);
        send_ref(PID_A, 20'd1, 1'b0);

        // Zero frames: every reference faults, nothing is placed
        program_table(4, 0, CNT_MAX);
        send_ref(PID_A, 20'd1, 1'b0);
        send_ref(PID_B, 20'd2, 1'b1);
        send_ref(PID_A, 20'd1, 1'b1);

        // Random phases over several settings
        run_phase(1, 64, CNT_MAX, 8, 60);
        run_phase(64, 1, CNT_MAX, 4, 40);
        run_phase(32, 64, 0, 24, 60);
        run_phase(64, 64, CNT_MAX, 32, 60);
        run_phase($urandom_range(2, 12), $urandom_range(3, 40), CNT_MAX,
                  $urandom_range(4, 32), 60);
        run_phase($urandom_range(2, 12), $urandom_range(3, 40), CNT_MAX,
                  $urandom_range(4, 32), 60);

        // Last phase without idling: reach the trace limit, then a few more
        no_idle = 1'b1;
        run_phase($urandom_range(1, 16), $urandom_range(8, 64), refs_sent + 40,
                  $urandom_range(4, 32), 48);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (12) @(posedge aclk);
        if (fail_count == 0) begin
            $display("inverted_page_table_fwf_tb: done, clean");
        end else begin
            $display("inverted_page_table_fwf_tb: done, errors");
        end
        $finish;
    end

endmodule
